// ===== rtl/interval_sort_buffer_roi_flush_top_assert.svh =====
// Assertion macros shared by the interval sort buffer RTL.
`ifndef INTERVAL_SORT_BUFFER_ROI_FLUSH_TOP_ASSERT_SVH
`define INTERVAL_SORT_BUFFER_ROI_FLUSH_TOP_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define ISBRF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define ISBRF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/isbrf_pkg.sv =====
// Types and constants of the interval sort buffer.
package isbrf_pkg;

    typedef struct packed {
        logic [15:0] tag;
        logic [14:0] tid;
        logic [30:0] pos;
        logic [30:0] end_pos;
    } rec_t;

    typedef struct packed {
        logic        enable;
        logic [14:0] tid;
        logic [30:0] start;
        logic [30:0] roi_end;
    } roi_cfg_t;

    localparam int REC_W = $bits(rec_t);

    // result kinds
    localparam logic [1:0] KIND_EMIT  = 2'd0;
    localparam logic [1:0] KIND_NONE  = 2'd1;
    localparam logic [1:0] KIND_FULL  = 2'd2;
    localparam logic [1:0] KIND_MERGE = 2'd3;

    // register indexes
    localparam logic [1:0] REG_ROI_ENABLE = 2'd0;
    localparam logic [1:0] REG_ROI_TID    = 2'd1;
    localparam logic [1:0] REG_ROI_START  = 2'd2;
    localparam logic [1:0] REG_ROI_END    = 2'd3;

    // a orders strictly after b: by id, then start, then end
    function automatic logic rec_after(input rec_t a, input rec_t b);
        rec_after = {a.tid, a.pos, a.end_pos} > {b.tid, b.pos, b.end_pos};
    endfunction

endpackage

// ===== rtl/isbrf_ram.sv =====
// Record store: one write port, one registered read port.
module isbrf_ram
    import isbrf_pkg::*;
#(
    parameter int DEPTH = 32,
    localparam int IDX_W = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  rec_t             wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output rec_t             rdata
);

    rec_t mem [DEPTH];
    rec_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // hold read data while no read is issued
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/isbrf_cfg.sv =====
// Region-of-interest register bank behind the APB port.
module isbrf_cfg
    import isbrf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output roi_cfg_t    roi
);

    roi_cfg_t roi_reg;
    roi_cfg_t roi_next;
    logic     wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        roi_next = roi_reg;
        if (wr_en) begin
            case (paddr[3:2])
                REG_ROI_ENABLE: roi_next.enable  = pwdata[0];
                REG_ROI_TID:    roi_next.tid     = pwdata[14:0];
                REG_ROI_START:  roi_next.start   = pwdata[30:0];
                REG_ROI_END:    roi_next.roi_end = pwdata[30:0];
                default:        roi_next = roi_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            roi_reg <= '0;
        end else begin
            roi_reg <= roi_next;
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_ROI_ENABLE: prdata = {31'd0, roi_reg.enable};
            REG_ROI_TID:    prdata = {17'd0, roi_reg.tid};
            REG_ROI_START:  prdata = {1'b0, roi_reg.start};
            REG_ROI_END:    prdata = {1'b0, roi_reg.roi_end};
            default:        prdata = 32'd0;
        endcase
    end

    assign roi = roi_reg;

endmodule

// ===== rtl/interval_sort_buffer_roi_flush_top.sv =====
// Interval sort buffer: keeps records sorted in a RAM, flushes up to the region of interest.
// Insert: writes directly into an empty buffer, else shifts larger records up one step per cycle.
// Flush: the RAM walk emits or compacts one record a cycle while the output does not stall.
// A result word shows the cycle after the one that loads it; flush records stream out mid-walk.
// Reset (synchronous, aresetn low) empties the buffer and clears the ROI registers;
// RAM contents are not cleared.
`include "interval_sort_buffer_roi_flush_top_assert.svh"

module interval_sort_buffer_roi_flush_top
    import isbrf_pkg::*;
#(
    parameter int BUFFER_DEPTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // rec_tag, rec_tid, rec_pos, rec_end_pos, zero pad
    input  logic        s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // out_tag, out_tid, out_pos, out_end_pos, zero pad
    output logic [1:0]  m_tuser,   // kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_INS      = 3'd1;
    localparam logic [2:0] ST_INS_PUT  = 3'd2;
    localparam logic [2:0] ST_FL_FIRST = 3'd3;
    localparam logic [2:0] ST_FL_LAST  = 3'd4;
    localparam logic [2:0] ST_WALK     = 3'd5;
    localparam logic [2:0] ST_DONE     = 3'd6;

    localparam logic [1:0] PH_ALL   = 2'd0;
    localparam logic [1:0] PH_LEAD  = 2'd1;
    localparam logic [1:0] PH_GROUP = 2'd2;
    localparam logic [1:0] PH_REST  = 2'd3;

    roi_cfg_t roi;

    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] keep_reg, keep_next;
    logic [1:0]       phase_reg, phase_next;
    rec_t             new_reg, new_next;
    logic [14:0]      tid0_reg, tid0_next;
    logic             roi_hit_reg, roi_hit_next;
    logic [30:0]      lpos_reg, lpos_next;
    logic [1:0]       kind_reg, kind_next;
    logic             pend_valid_reg, pend_valid_next;
    rec_t             pend_rec_reg, pend_rec_next;
    logic             m_tvalid_reg, m_tvalid_next;
    rec_t             m_rec_reg;
    logic [1:0]       m_kind_reg;
    logic             m_last_reg;

    rec_t             in_rec;
    rec_t             ram_rdata;
    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    rec_t             ram_wdata;
    logic [IDX_W-1:0] last_idx;
    logic             full;
    logic             out_free;
    logic             out_load;
    rec_t             out_rec;
    logic [1:0]       out_kind;
    logic             out_last;
    logic             emit, keep_w, stall;
    logic             lead_emit, overlap;

    isbrf_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .roi     (roi)
    );

    isbrf_ram #(
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_rec.tag     = s_tdata[15:0];
    assign in_rec.tid     = s_tdata[30:16];
    assign in_rec.pos     = s_tdata[61:31];
    assign in_rec.end_pos = s_tdata[92:62];

    assign s_tready = (state_reg == ST_IDLE);
    assign last_idx = IDX_W'(cnt_reg - 1'b1);
    assign full     = (cnt_reg == CNT_W'(BUFFER_DEPTH));
    assign out_free = !m_tvalid_reg || m_tready;

    // walk decisions on the record just read
    assign lead_emit = (ram_rdata.end_pos <= roi.start);
    assign overlap   = (ram_rdata.end_pos > roi.start) && (ram_rdata.pos < roi.roi_end) &&
                       (ram_rdata.tid == roi.tid);

    always_comb begin
        emit   = 1'b0;
        keep_w = 1'b0;
        case (phase_reg)
            PH_ALL: emit = 1'b1;
            PH_LEAD: begin
                if (lead_emit) begin
                    emit = 1'b1;
                end else begin
                    keep_w = overlap;
                    emit   = !overlap;
                end
            end
            PH_GROUP: begin
                if (ram_rdata.pos == lpos_reg) begin
                    keep_w = overlap;
                    emit   = !overlap;
                end else begin
                    keep_w = 1'b1;
                end
            end
            PH_REST: keep_w = 1'b1;
            default: emit = 1'b0;
        endcase
    end

    assign stall = emit && pend_valid_reg && !out_free;

    always_comb begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        keep_next       = keep_reg;
        phase_next      = phase_reg;
        new_next        = new_reg;
        tid0_next       = tid0_reg;
        roi_hit_next    = roi_hit_reg;
        lpos_next       = lpos_reg;
        kind_next       = kind_reg;
        pend_valid_next = pend_valid_reg;
        pend_rec_next   = pend_rec_reg;
        ram_we          = 1'b0;
        ram_waddr       = idx_reg;
        ram_wdata       = new_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        out_load        = 1'b0;
        out_rec         = '0;
        out_kind        = KIND_EMIT;
        out_last        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    new_next = in_rec;
                    if (!s_tuser) begin
                        if (full) begin
                            kind_next  = KIND_FULL;
                            state_next = ST_DONE;
                        end else if (cnt_reg == '0) begin
                            ram_we     = 1'b1;
                            ram_waddr  = '0;
                            ram_wdata  = in_rec;
                            cnt_next   = cnt_reg + 1'b1;
                            kind_next  = KIND_NONE;
                            state_next = ST_DONE;
                        end else begin
                            ram_re     = 1'b1;
                            ram_raddr  = last_idx;
                            idx_next   = IDX_W'(cnt_reg);
                            state_next = ST_INS;
                        end
                    end else if (cnt_reg == '0) begin
                        kind_next  = KIND_NONE;
                        state_next = ST_DONE;
                    end else begin
                        ram_re     = 1'b1;
                        ram_raddr  = '0;
                        state_next = ST_FL_FIRST;
                    end
                end
            end
            ST_INS: begin
                // shift larger records up one slot, drop the new one behind equals
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (rec_after(ram_rdata, new_reg)) begin
                    ram_wdata = ram_rdata;
                    idx_next  = idx_reg - 1'b1;
                    if (idx_reg == IDX_W'(1)) begin
                        state_next = ST_INS_PUT;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg - IDX_W'(2);
                    end
                end else begin
                    ram_wdata  = new_reg;
                    cnt_next   = cnt_reg + 1'b1;
                    kind_next  = KIND_NONE;
                    state_next = ST_DONE;
                end
            end
            ST_INS_PUT: begin
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = new_reg;
                cnt_next   = cnt_reg + 1'b1;
                kind_next  = KIND_NONE;
                state_next = ST_DONE;
            end
            ST_FL_FIRST: begin
                tid0_next    = ram_rdata.tid;
                roi_hit_next = roi.enable && (roi.tid == ram_rdata.tid);
                ram_re       = 1'b1;
                ram_raddr    = last_idx;
                state_next   = ST_FL_LAST;
            end
            ST_FL_LAST: begin
                if ((new_reg.tid == tid0_reg) && (new_reg.pos < ram_rdata.pos)) begin
                    kind_next  = KIND_MERGE;
                    state_next = ST_DONE;
                end else begin
                    ram_re     = 1'b1;
                    ram_raddr  = '0;
                    idx_next   = '0;
                    keep_next  = '0;
                    phase_next = roi_hit_reg ? PH_LEAD : PH_ALL;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (!stall) begin
                    if (phase_reg == PH_LEAD && !lead_emit) begin
                        lpos_next  = ram_rdata.pos;
                        phase_next = PH_GROUP;
                    end else if (phase_reg == PH_GROUP && ram_rdata.pos != lpos_reg) begin
                        phase_next = PH_REST;
                    end
                    // hold one emitted word back so the final one can carry last
                    if (emit) begin
                        if (pend_valid_reg) begin
                            out_load = 1'b1;
                            out_rec  = pend_rec_reg;
                        end
                        pend_rec_next   = ram_rdata;
                        pend_valid_next = 1'b1;
                    end
                    if (keep_w) begin
                        ram_we    = 1'b1;
                        ram_waddr = keep_reg[IDX_W-1:0];
                        ram_wdata = ram_rdata;
                        keep_next = keep_reg + 1'b1;
                    end
                    if (idx_reg == last_idx) begin
                        cnt_next   = keep_w ? keep_reg + 1'b1 : keep_reg;
                        kind_next  = KIND_NONE;
                        state_next = ST_DONE;
                    end else begin
                        idx_next  = idx_reg + 1'b1;
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + 1'b1;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_last = 1'b1;
                    if (pend_valid_reg) begin
                        out_rec = pend_rec_reg;
                    end else begin
                        out_kind = kind_reg;
                    end
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        keep_reg     <= keep_next;
        phase_reg    <= phase_next;
        new_reg      <= new_next;
        tid0_reg     <= tid0_next;
        roi_hit_reg  <= roi_hit_next;
        lpos_reg     <= lpos_next;
        kind_reg     <= kind_next;
        pend_rec_reg <= pend_rec_next;
        if (out_load) begin
            m_rec_reg  <= out_rec;
            m_kind_reg <= out_kind;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {3'b000, m_rec_reg.end_pos, m_rec_reg.pos, m_rec_reg.tid, m_rec_reg.tag};

    `ISBRF_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_reg <= CNT_W'(BUFFER_DEPTH), "record count over depth")
    `ISBRF_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, state_reg != ST_IDLE, "accepted word left block idle")
    `ISBRF_ASSERT_IMP(a_pend_in_flush, pend_valid_reg, state_reg == ST_WALK || state_reg == ST_DONE, "pending word outside flush")
    `ISBRF_ASSERT_IMP(a_keep_behind_read, state_reg == ST_WALK, keep_reg <= CNT_W'(idx_reg), "compaction overtook read pointer")
    `ISBRF_ASSERT_IMP(a_load_needs_room, out_load, out_free, "output register overwritten")

endmodule
